FILE: design/ps2s_pkg.sv
// Package for the PS/2 scan code set 1 to ASCII translator.
// Holds the command struct between front and back, the key codes and the
// character tables. No dependencies.
package ps2s_pkg;

    localparam int TableLen = 58;
    localparam int IndexW   = $clog2(TableLen);
    localparam int CharW    = 7;
    localparam int CodeW    = 8;

    localparam logic [CodeW-1:0] CodePrefix     = 8'hE0;
    localparam logic [CodeW-1:0] CodeLShiftMake = 8'h2A;
    localparam logic [CodeW-1:0] CodeRShiftMake = 8'h36;
    localparam logic [CodeW-1:0] CodeLShiftBrk  = 8'hAA;
    localparam logic [CodeW-1:0] CodeRShiftBrk  = 8'hB6;
    localparam logic [CodeW-1:0] CodeCapsMake   = 8'h3A;

    localparam logic [CharW-1:0] CaseBit = 7'h20;

    // One table lookup handed from the front to the back.
    typedef struct packed {
        logic [IndexW-1:0] index;
        logic              shifted;
        logic              caps;
    } t_cmd;

    localparam logic [CharW-1:0] PlainMap [TableLen] = '{
        7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
        7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
        7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
        7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
        7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
        7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20
    };

    localparam logic [CharW-1:0] ShiftedMap [TableLen] = '{
        7'h00, 7'h01, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
        7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
        7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
        7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
        7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
        7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20
    };

endpackage

FILE: design/ps2_scancode_to_ascii.sv
// Top level of the PS/2 scan code set 1 to ASCII translator.
// Instantiates ps2s_front, ps2s_queue and ps2s_back; depends on ps2s_pkg.
//
// The block takes one set 1 scan code byte per input beat and gives at most
// one 7-bit ASCII character per output beat. It tracks shift, caps lock and
// the 0xE0 extended prefix: the byte after a prefix is dropped, break codes
// only release shift (0xAA, 0xB6), make codes 0x2A and 0x36 press shift and
// 0x3A toggles caps lock on every make, repeats included. Make codes below
// 0x3A are looked up in a plain or shifted table, letter case is inverted
// while caps lock is on, and zero entries produce no output beat. An input
// beat is taken every cycle as long as the two-entry lookup queue is not
// full; the front updates the flags in the cycle of acceptance, and the back
// pops one queued lookup per cycle into its output register whenever that
// register is empty or being drained. A character passes through a queue
// entry and then the output register before it appears on the output, at a
// sustained rate of one beat per cycle when the receiver keeps i_ready high.
module ps2_scancode_to_ascii (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [ps2s_pkg::CodeW-1:0] i_scan_code,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [ps2s_pkg::CharW-1:0] o_char_code
);
    import ps2s_pkg::*;

    logic push, full, pop, nonempty;
    t_cmd front_cmd, back_cmd;

    ps2s_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_scan_code (i_scan_code),
        .o_push      (push),
        .o_cmd       (front_cmd),
        .i_full      (full)
    );

    ps2s_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_cmd      (front_cmd),
        .o_full     (full),
        .i_pop      (pop),
        .o_nonempty (nonempty),
        .o_cmd      (back_cmd)
    );

    ps2s_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_nonempty  (nonempty),
        .i_cmd       (back_cmd),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_char_code (o_char_code)
    );
endmodule

FILE: design/ps2s_front.sv
// Front part of the translator: takes scan code beats, keeps the keyboard
// flags and issues a table lookup command for make codes inside the table.
// Depends on ps2s_pkg.
module ps2s_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [ps2s_pkg::CodeW-1:0] i_scan_code,
    output logic                       o_push,
    output ps2s_pkg::t_cmd             o_cmd,
    input  logic                       i_full
);
    import ps2s_pkg::*;

    logic r_shift, n_shift;
    logic r_caps, n_caps;
    logic r_prefix, n_prefix;
    logic accept;
    logic lookup;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_shift  = r_shift;
        n_caps   = r_caps;
        n_prefix = r_prefix;
        lookup   = 1'b0;
        if (i_scan_code == CodePrefix) begin
            n_prefix = 1'b1;
        end else if (r_prefix) begin
            n_prefix = 1'b0;
        end else if (i_scan_code[CodeW-1]) begin
            if (i_scan_code == CodeLShiftBrk || i_scan_code == CodeRShiftBrk) begin
                n_shift = 1'b0;
            end
        end else begin
            if (i_scan_code == CodeLShiftMake || i_scan_code == CodeRShiftMake) begin
                n_shift = 1'b1;
            end
            if (i_scan_code == CodeCapsMake) begin
                n_caps = !r_caps;
            end
            lookup = (i_scan_code < CodeW'(TableLen));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift  <= 1'b0;
            r_caps   <= 1'b0;
            r_prefix <= 1'b0;
        end else if (accept) begin
            r_shift  <= n_shift;
            r_caps   <= n_caps;
            r_prefix <= n_prefix;
        end
    end

    assign o_push        = accept && lookup;
    assign o_cmd.index   = i_scan_code[IndexW-1:0];
    assign o_cmd.shifted = n_shift;
    assign o_cmd.caps    = n_caps;

    a_prefix_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_scan_code == CodePrefix |=> r_prefix)
        else $error("prefix flag not set after prefix byte");
    a_no_push_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_prefix && accept |-> !o_push)
        else $error("byte after prefix issued a lookup");
endmodule

FILE: design/ps2s_queue.sv
// Two-entry command queue between the front and the back of the translator.
// Depends on ps2s_pkg.
module ps2s_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ps2s_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_nonempty,
    output ps2s_pkg::t_cmd o_cmd
);
    import ps2s_pkg::*;

    localparam int Depth = 2;
    localparam int PtrW  = $clog2(Depth);

    t_cmd              r_mem [Depth];
    logic [PtrW-1:0]   r_wptr, r_rptr;
    logic [PtrW:0]     r_count;

    assign o_full     = (r_count == (PtrW+1)'(Depth));
    assign o_nonempty = (r_count != '0);
    assign o_cmd      = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_nonempty))
        else $error("pop from empty queue");
endmodule

FILE: design/ps2s_back.sv
// Back part of the translator: looks up the character, applies caps lock and
// holds nonzero characters in the output register. Depends on ps2s_pkg.
module ps2s_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_nonempty,
    input  ps2s_pkg::t_cmd             i_cmd,
    output logic                       o_pop,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [ps2s_pkg::CharW-1:0] o_char_code
);
    import ps2s_pkg::*;

    logic             r_valid, n_valid;
    logic [CharW-1:0] r_char;
    logic [CharW-1:0] raw_char, fin_char;

    always_comb begin
        raw_char = i_cmd.shifted ? ShiftedMap[i_cmd.index] : PlainMap[i_cmd.index];
        fin_char = raw_char;
        if (i_cmd.caps) begin
            if (raw_char inside {[7'h61:7'h7A]}) begin
                fin_char = raw_char & ~CaseBit;
            end else if (raw_char inside {[7'h41:7'h5A]}) begin
                fin_char = raw_char | CaseBit;
            end
        end
    end

    // A lookup that yields zero is popped and dropped.
    assign o_pop = i_nonempty && (!r_valid || i_ready);

    always_comb begin
        n_valid = r_valid && !i_ready;
        if (o_pop && fin_char != '0) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && fin_char != '0) begin
            r_char <= fin_char;
        end
    end

    assign o_valid     = r_valid;
    assign o_char_code = r_char;

    a_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> r_char != '0)
        else $error("zero character presented");
endmodule
